// File: hdl/piecewise_linear_interpolator_assert.svh
// Assertion macros for the interpolator checker
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define PLI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PLI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/pli_pkg.sv
// Shared types, constants and microprogram of the interpolator
package pli_pkg;

	localparam int MAX_POINTS = 64;
	localparam int COORD_W    = 32;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int INDEX_W    = 6;
	localparam int COUNT_W    = 7;
	localparam int CFG_DATA_W = 7;
	localparam int CFG_INDEX_W = 1;
	localparam int STATUS_W   = 2;

	// divider widths: magnitude of a value difference, remainder headroom
	localparam int MAG_W = COORD_W + 1;
	localparam int R2_W  = COORD_W + 2;
	localparam int CNT_W = $clog2(MAG_W);

	localparam logic [CFG_INDEX_W-1:0] REG_INTERP_MODE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_POINT_COUNT = 1'd1;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_IN_RANGE = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BELOW    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BEYOND   = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_LOAD     = 2'd3;

	typedef struct packed {
		logic                      cmd;
		logic [INDEX_W-1:0]        entry_index;
		logic signed [COORD_W-1:0] position;
		logic signed [COORD_W-1:0] entry_value;
	} in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] result_value;
		logic [STATUS_W-1:0]       status;
	} out_t;

	// datapath operations
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
	localparam logic [OP_W-1:0] OP_IDLE    = 4'd1;
	localparam logic [OP_W-1:0] OP_TOP     = 4'd2;
	localparam logic [OP_W-1:0] OP_RES_VAL = 4'd3;
	localparam logic [OP_W-1:0] OP_FIRST   = 4'd4;
	localparam logic [OP_W-1:0] OP_SCAN    = 4'd5;
	localparam logic [OP_W-1:0] OP_SETUP   = 4'd6;
	localparam logic [OP_W-1:0] OP_DIV     = 4'd7;
	localparam logic [OP_W-1:0] OP_FINISH  = 4'd8;
	localparam logic [OP_W-1:0] OP_EMIT    = 4'd9;

	// table read address select
	localparam int RSEL_W = 2;
	localparam logic [RSEL_W-1:0] RA_LAST = 2'd0;
	localparam logic [RSEL_W-1:0] RA_PREV = 2'd1;
	localparam logic [RSEL_W-1:0] RA_ZERO = 2'd2;
	localparam logic [RSEL_W-1:0] RA_K    = 2'd3;

	// jump conditions
	localparam int COND_W = 4;
	localparam logic [COND_W-1:0] C_NEXT      = 4'd0;
	localparam logic [COND_W-1:0] C_ALWAYS    = 4'd1;
	localparam logic [COND_W-1:0] C_NO_QUERY  = 4'd2;
	localparam logic [COND_W-1:0] C_X_BELOW   = 4'd3;
	localparam logic [COND_W-1:0] C_LINEAR    = 4'd4;
	localparam logic [COND_W-1:0] C_SCAN_ON   = 4'd5;
	localparam logic [COND_W-1:0] C_NO_INTERP = 4'd6;
	localparam logic [COND_W-1:0] C_DIV_BUSY  = 4'd7;
	localparam logic [COND_W-1:0] C_OUT_BUSY  = 4'd8;

	// program steps
	localparam int UPC_W = 4;
	localparam logic [UPC_W-1:0] S_IDLE      = 4'd0;
	localparam logic [UPC_W-1:0] S_RD_LAST   = 4'd1;
	localparam logic [UPC_W-1:0] S_CHK_LAST  = 4'd2;
	localparam logic [UPC_W-1:0] S_LINEAR    = 4'd3;
	localparam logic [UPC_W-1:0] S_STEP_VAL  = 4'd4;
	localparam logic [UPC_W-1:0] S_RD_FIRST  = 4'd5;
	localparam logic [UPC_W-1:0] S_CHK_FIRST = 4'd6;
	localparam logic [UPC_W-1:0] S_SCAN_RD   = 4'd7;
	localparam logic [UPC_W-1:0] S_SCAN_CHK  = 4'd8;
	localparam logic [UPC_W-1:0] S_SETUP     = 4'd9;
	localparam logic [UPC_W-1:0] S_DIV       = 4'd10;
	localparam logic [UPC_W-1:0] S_FINISH    = 4'd11;
	localparam logic [UPC_W-1:0] S_EMIT      = 4'd12;
	localparam logic [UPC_W-1:0] S_RETURN    = 4'd13;

	typedef struct packed {
		logic [UPC_W-1:0]  target;
		logic [COND_W-1:0] cond;
		logic [RSEL_W-1:0] rsel;
		logic [OP_W-1:0]   op;
	} uword_t;

	typedef struct packed {
		logic query_start;
		logic x_below;
		logic linear;
		logic scan_on;
		logic no_interp;
		logic div_busy;
		logic out_busy;
	} flags_t;

	function automatic uword_t uw(input logic [OP_W-1:0] op, input logic [RSEL_W-1:0] rsel,
			input logic [COND_W-1:0] cond, input logic [UPC_W-1:0] target);
		uword_t w;
		w.op     = op;
		w.rsel   = rsel;
		w.cond   = cond;
		w.target = target;
		return w;
	endfunction

	// control store; on a true condition jump to target, else fall through
	function automatic uword_t ucode(input logic [UPC_W-1:0] step);
		uword_t w;
		unique case (step)
			S_IDLE:      w = uw(OP_IDLE,    RA_LAST, C_NO_QUERY,  S_IDLE);
			S_RD_LAST:   w = uw(OP_NOP,     RA_LAST, C_NEXT,      S_IDLE);
			S_CHK_LAST:  w = uw(OP_TOP,     RA_PREV, C_X_BELOW,   S_RD_FIRST);
			S_LINEAR:    w = uw(OP_NOP,     RA_PREV, C_LINEAR,    S_EMIT);
			S_STEP_VAL:  w = uw(OP_RES_VAL, RA_ZERO, C_ALWAYS,    S_EMIT);
			S_RD_FIRST:  w = uw(OP_NOP,     RA_ZERO, C_NEXT,      S_IDLE);
			S_CHK_FIRST: w = uw(OP_FIRST,   RA_ZERO, C_X_BELOW,   S_EMIT);
			S_SCAN_RD:   w = uw(OP_NOP,     RA_K,    C_NEXT,      S_IDLE);
			S_SCAN_CHK:  w = uw(OP_SCAN,    RA_K,    C_SCAN_ON,   S_SCAN_RD);
			S_SETUP:     w = uw(OP_SETUP,   RA_K,    C_NO_INTERP, S_EMIT);
			S_DIV:       w = uw(OP_DIV,     RA_K,    C_DIV_BUSY,  S_DIV);
			S_FINISH:    w = uw(OP_FINISH,  RA_K,    C_NEXT,      S_IDLE);
			S_EMIT:      w = uw(OP_EMIT,    RA_K,    C_OUT_BUSY,  S_EMIT);
			S_RETURN:    w = uw(OP_NOP,     RA_K,    C_ALWAYS,    S_IDLE);
			default:     w = uw(OP_NOP,     RA_K,    C_ALWAYS,    S_IDLE);
		endcase
		return w;
	endfunction

endpackage

// File: hdl/pli_ram.sv
// Generic single-write, single-read RAM with registered read data
module pli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/pli_sequencer.sv
// Microprogram counter, control store fetch and jump logic
module pli_sequencer (
	input  logic            clk,
	input  logic            arst_n,
	input  pli_pkg::flags_t flags,
	output pli_pkg::uword_t ctrl
);

	logic [pli_pkg::UPC_W-1:0] upc_q;
	logic                      take;

	assign ctrl = pli_pkg::ucode(upc_q);

	always_comb begin
		unique case (ctrl.cond)
			pli_pkg::C_NEXT:      take = 1'b0;
			pli_pkg::C_ALWAYS:    take = 1'b1;
			pli_pkg::C_NO_QUERY:  take = !flags.query_start;
			pli_pkg::C_X_BELOW:   take = flags.x_below;
			pli_pkg::C_LINEAR:    take = flags.linear;
			pli_pkg::C_SCAN_ON:   take = flags.scan_on;
			pli_pkg::C_NO_INTERP: take = flags.no_interp;
			pli_pkg::C_DIV_BUSY:  take = flags.div_busy;
			pli_pkg::C_OUT_BUSY:  take = flags.out_busy;
			default:              take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= pli_pkg::S_IDLE;
		end else if (take) begin
			upc_q <= ctrl.target;
		end else begin
			upc_q <= upc_q + 1'b1;
		end
	end

endmodule

// File: hdl/pli_datapath.sv
// Breakpoint tables, config registers, scan and multiply-divide datapath
module pli_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [pli_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [pli_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  pli_pkg::in_t                       in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output pli_pkg::out_t                      out_data,
	input  pli_pkg::uword_t                    ctrl,
	output pli_pkg::flags_t                    flags
);

	localparam int CW = pli_pkg::COORD_W;
	localparam int MW = pli_pkg::MAG_W;
	localparam int RW = pli_pkg::R2_W;
	localparam int AW = pli_pkg::ADDR_W;

	logic                         mode_q;
	logic [pli_pkg::COUNT_W-1:0]  count_q;
	logic [AW-1:0]                last;
	logic [AW-1:0]                raddr;
	logic [CW-1:0]                rpos;
	logic [CW-1:0]                rval;
	logic                         load_take;
	logic                         ram_we;
	logic                         emit;

	logic [CW-1:0]                x_q;
	logic [CW-1:0]                pa_q;
	logic [CW-1:0]                va_q;
	logic [CW-1:0]                pb_q;
	logic [CW-1:0]                vb_q;
	logic [AW-1:0]                k_q;
	logic [CW-1:0]                res_q;
	logic [pli_pkg::STATUS_W-1:0] status_q;

	logic [MW-1:0]                mag_q;
	logic                         neg_q;
	logic [CW-1:0]                dx_q;
	logic [CW-1:0]                dp_q;
	logic [CW-1:0]                rem_q;
	logic [MW-1:0]                quo_q;
	logic [pli_pkg::CNT_W-1:0]    cnt_q;

	logic [MW-1:0]                dv;
	logic [RW-1:0]                r2;
	logic [RW-1:0]                c1;
	logic [RW-1:0]                c2;
	logic [RW-1:0]                rem_d;
	logic [1:0]                   inc;
	logic [MW-1:0]                va_ext;
	logic [MW-1:0]                sum;
	logic                         out_busy;

	// clamp point_count into 2..MAX_POINTS, keep the last index
	always_comb begin
		if (int'(count_q) < 2) begin
			last = AW'(1);
		end else if (int'(count_q) > pli_pkg::MAX_POINTS) begin
			last = AW'(pli_pkg::MAX_POINTS - 1);
		end else begin
			last = AW'(count_q - 1'b1);
		end
	end

	always_comb begin
		unique case (ctrl.rsel)
			pli_pkg::RA_LAST: raddr = last;
			pli_pkg::RA_PREV: raddr = last - 1'b1;
			pli_pkg::RA_ZERO: raddr = '0;
			pli_pkg::RA_K:    raddr = k_q;
			default:          raddr = k_q;
		endcase
	end

	assign out_busy  = out_valid && !out_ready;
	assign in_ready  = (ctrl.op == pli_pkg::OP_IDLE) && !out_busy;
	assign load_take = in_valid && in_ready && (in_data.cmd == pli_pkg::CMD_LOAD);
	assign ram_we    = load_take && (int'(in_data.entry_index) < pli_pkg::MAX_POINTS);
	assign emit      = (ctrl.op == pli_pkg::OP_EMIT) && !out_busy;

	pli_ram #(.WIDTH(CW), .DEPTH(pli_pkg::MAX_POINTS)) u_pos_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(in_data.entry_index)),
		.wdata (in_data.position),
		.raddr (raddr),
		.rdata (rpos)
	);

	pli_ram #(.WIDTH(CW), .DEPTH(pli_pkg::MAX_POINTS)) u_val_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(in_data.entry_index)),
		.wdata (in_data.entry_value),
		.raddr (raddr),
		.rdata (rval)
	);

	assign flags.query_start = in_valid && in_ready && (in_data.cmd == pli_pkg::CMD_QUERY);
	assign flags.x_below     = $signed(x_q) < $signed(rpos);
	assign flags.linear      = mode_q;
	assign flags.scan_on     = ($signed(rpos) <= $signed(x_q)) && (k_q != last);
	assign flags.no_interp   = (x_q == pa_q) || !mode_q;
	assign flags.div_busy    = cnt_q != '0;
	assign flags.out_busy    = out_busy;

	// radix-2 multiply-divide step: r2 < 3*dp, so at most two subtracts of dp
	assign dv = {vb_q[CW-1], vb_q} - {va_q[CW-1], va_q};
	assign r2 = {1'b0, rem_q, 1'b0} + (mag_q[MW-1] ? {2'b00, dx_q} : RW'(0));
	assign c1 = {2'b00, dp_q};
	assign c2 = {1'b0, dp_q, 1'b0};

	always_comb begin
		if (r2 >= c2) begin
			rem_d = r2 - c2;
			inc   = 2'd2;
		end else if (r2 >= c1) begin
			rem_d = r2 - c1;
			inc   = 2'd1;
		end else begin
			rem_d = r2;
			inc   = 2'd0;
		end
	end

	assign va_ext = {va_q[CW-1], va_q};
	assign sum    = neg_q ? va_ext - quo_q : va_ext + quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b1;
			count_q   <= pli_pkg::COUNT_W'(2);
			out_valid <= 1'b0;
			k_q       <= '0;
			cnt_q     <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					pli_pkg::REG_INTERP_MODE: mode_q  <= cfg_data[0];
					pli_pkg::REG_POINT_COUNT: count_q <= cfg_data[pli_pkg::COUNT_W-1:0];
					default: ;
				endcase
			end
			if (load_take || emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (ctrl.op)
				pli_pkg::OP_FIRST: k_q   <= AW'(1);
				pli_pkg::OP_SCAN:  k_q   <= flags.scan_on ? k_q + 1'b1 : k_q;
				pli_pkg::OP_SETUP: cnt_q <= pli_pkg::CNT_W'(MW - 1);
				pli_pkg::OP_DIV:   cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_take) begin
			out_data.result_value <= '0;
			out_data.status       <= pli_pkg::STATUS_LOAD;
		end else if (emit) begin
			out_data.result_value <= res_q;
			out_data.status       <= status_q;
		end
		unique case (ctrl.op)
			pli_pkg::OP_IDLE: begin
				if (flags.query_start) begin
					x_q <= in_data.position;
				end
			end
			pli_pkg::OP_TOP: begin
				res_q    <= rval;
				status_q <= pli_pkg::STATUS_BEYOND;
			end
			pli_pkg::OP_RES_VAL: begin
				res_q <= rval;
			end
			pli_pkg::OP_FIRST: begin
				res_q    <= rval;
				status_q <= pli_pkg::STATUS_BELOW;
				pa_q     <= rpos;
				va_q     <= rval;
			end
			pli_pkg::OP_SCAN: begin
				if (flags.scan_on) begin
					pa_q <= rpos;
					va_q <= rval;
				end else begin
					pb_q <= rpos;
					vb_q <= rval;
				end
			end
			pli_pkg::OP_SETUP: begin
				res_q    <= va_q;
				status_q <= pli_pkg::STATUS_IN_RANGE;
				neg_q    <= dv[MW-1];
				mag_q    <= dv[MW-1] ? -dv : dv;
				dx_q     <= x_q - pa_q;
				dp_q     <= pb_q - pa_q;
				rem_q    <= '0;
				quo_q    <= '0;
			end
			pli_pkg::OP_DIV: begin
				mag_q <= {mag_q[MW-2:0], 1'b0};
				rem_q <= rem_d[CW-1:0];
				quo_q <= {quo_q[MW-2:0], 1'b0} + MW'(inc);
			end
			pli_pkg::OP_FINISH: begin
				res_q <= sum[CW-1:0];
			end
			default: ;
		endcase
	end

endmodule

// File: hdl/piecewise_linear_interpolator.sv
// Top level: piecewise linear interpolator over a breakpoint table
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_write            cfg_index, cfg_data
//   in       in         in_valid / in_ready  in_data (pli_pkg::in_t)
//   out      out        out_valid / out_ready out_data (pli_pkg::out_t)
//
// Loads answer on the next cycle, back to back. A query reads the last and first
// points, then scans the points in turn, a read step and a check step for each;
// interpolating then runs a 33-step divide, skipped when the query lies beyond the
// last point, below the first, or in range in step mode or on a breakpoint.
// Reset clears config (linear mode, two points) and control; tables are not cleared.
// Requests need the idle step and a free output register; a stalled output holds it.
module piecewise_linear_interpolator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [pli_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pli_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  pli_pkg::in_t                    in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output pli_pkg::out_t                   out_data
);

	pli_pkg::uword_t ctrl;
	pli_pkg::flags_t flags;

	pli_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	pli_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.ctrl      (ctrl),
		.flags     (flags)
	);

endmodule

// File: hdl/pli_checker.sv
// Port-level checker for the interpolator, bound to the top level
`include "piecewise_linear_interpolator_assert.svh"

module pli_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input pli_pkg::in_t  in_data,
	input logic          out_valid,
	input logic          out_ready,
	input pli_pkg::out_t out_data
);

	logic load_req;
	logic query_req;

	assign load_req  = in_valid && in_ready && (in_data.cmd == pli_pkg::CMD_LOAD);
	assign query_req = in_valid && in_ready && (in_data.cmd == pli_pkg::CMD_QUERY);

	`PLI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped or changed while stalled")
	`PLI_ASSERT_NEXT(a_load_done, load_req, out_valid && (out_data.status == pli_pkg::STATUS_LOAD) && (out_data.result_value == '0), "load request did not answer load done")
	`PLI_ASSERT_NEXT(a_query_busy, query_req, !in_ready, "new request taken while a query is in progress")
	`PLI_ASSERT_NOW(a_ready_free, in_ready, !out_valid || out_ready, "request taken while output register is blocked")

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (.*);
